@@ rtl/core/fpsc_pkg.sv @@
package fpsc_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ABS,
    ST_MLO,
    ST_MHI,
    ST_MAG,
    ST_PLO,
    ST_PHI,
    ST_SUM,
    ST_POS,
    ST_CNT,
    ST_SEG,
    ST_DMUL,
    ST_DINIT,
    ST_DIV,
    ST_DFIN,
    ST_DONE
  } state_t;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_FREQUENCY    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTINUOUS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BREAKPOINT_0      = 3'd3;

  localparam logic [3:0] LAST_ROW  = 4'd9;

  // Full-step commutation rows: high-side phases, bit 0 is phase A.
  function automatic logic [4:0] high_mask(input logic [3:0] row);
    logic [4:0] m;
    case (row)
      4'd0:    m = 5'b00001;
      4'd1:    m = 5'b00011;
      4'd2:    m = 5'b00010;
      4'd3:    m = 5'b00110;
      4'd4:    m = 5'b00100;
      4'd5:    m = 5'b01100;
      4'd6:    m = 5'b01000;
      4'd7:    m = 5'b11000;
      4'd8:    m = 5'b10000;
      4'd9:    m = 5'b10001;
      default: m = 5'b00000;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] low_mask(input logic [3:0] row);
    logic [4:0] m;
    case (row)
      4'd0:    m = 5'b01100;
      4'd1:    m = 5'b01000;
      4'd2:    m = 5'b11000;
      4'd3:    m = 5'b10000;
      4'd4:    m = 5'b10001;
      4'd5:    m = 5'b00001;
      4'd6:    m = 5'b00011;
      4'd7:    m = 5'b00010;
      4'd8:    m = 5'b00110;
      4'd9:    m = 5'b00100;
      default: m = 5'b00000;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/five_phase_stepper_commutator.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     target_count, speed_limit
// out       output     out_valid / out_ready   high_duty_a..e, low_side_mask, phase_index,
//                                              current_count, actual_speed
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each item runs through the sequencer states in order; a duty read straight from a breakpoint
// skips the interpolation, which uses the 16-step restoring divider and the shared 32x32
// multiplier. The next item is taken once the previous result sits in the output
// register. Reset is synchronous; it restores the register defaults and clears the tracked
// position, the whole-step count and the commutation row. A stalled output holds the
// sequencer in its final state until the result register is free.
module five_phase_stepper_commutator #(
  parameter int BREAKPOINTS = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   target_count,
  input  logic signed [31:0]                   speed_limit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [15:0]                          high_duty_a,
  output logic [15:0]                          high_duty_b,
  output logic [15:0]                          high_duty_c,
  output logic [15:0]                          high_duty_d,
  output logic [15:0]                          high_duty_e,
  output logic [4:0]                           low_side_mask,
  output logic [3:0]                           phase_index,
  output logic signed [31:0]                   current_count,
  output logic signed [31:0]                   actual_speed,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fpsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [47:0]                          cfg_data
);

  localparam int IW = $clog2(BREAKPOINTS + 1);

  fpsc_pkg::state_t state, state_next;

  logic [15:0] tick_frequency;
  logic [31:0] tick_period;
  logic        continuous;
  logic [47:0] bp [BREAKPOINTS];

  logic [47:0] position;
  logic [31:0] last_count;
  logic [3:0]  step;

  logic signed [31:0] tgt;
  logic [31:0] lim;
  logic [48:0] diff;
  logic [48:0] a;
  logic        dneg;
  logic [63:0] prod;
  logic [47:0] acc;
  logic [47:0] mag;
  logic [47:0] msum;
  logic [31:0] cnt;
  logic [31:0] spd;
  logic [15:0] y1;
  logic [15:0] dyabs;
  logic        dyneg;
  logic [31:0] sx;
  logic [31:0] dx;
  logic [31:0] rem;
  logic [15:0] nlo;
  logic [15:0] quot;
  logic [3:0]  div_cnt;
  logic [15:0] duty;

  logic [31:0] mul_x, mul_y;

  // Combinational helpers.
  logic [31:0] lim_abs, cap, lim_clamped;
  logic [47:0] lim_q16;
  logic [63:0] full;
  logic [31:0] count_now;
  logic [47:0] pos_round;
  logic [31:0] s;
  logic [IW-1:0] idx;
  logic [47:0] seg_lo, seg_hi;
  logic        direct;
  logic [15:0] direct_duty;
  logic [32:0] r2;
  logic        spd_neg;

  assign in_ready  = (state == fpsc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign lim_abs     = speed_limit[31] ? 32'(-speed_limit) : 32'(speed_limit);
  assign cap         = bp[BREAKPOINTS-1][47:16];
  assign lim_clamped = (lim_abs > cap) ? cap : lim_abs;
  assign lim_q16     = {lim, 16'b0};
  assign full        = {16'b0, acc} + {prod[31:0], 32'b0};
  assign s           = mag[47:16];
  assign spd_neg     = dneg && (mag != 48'd0);

  // Truncation toward zero of the Q16 position.
  assign pos_round = position[47] ? (position + 48'hFFFF) : position;
  assign count_now = 32'($signed(pos_round) >>> 16);

  assign r2 = {rem, nlo[15]};

  always_comb begin
    mul_x = 32'b0;
    mul_y = 32'b0;
    unique case (state)
      fpsc_pkg::ST_MLO: begin
        mul_x = a[31:0];
        mul_y = {16'b0, tick_frequency};
      end
      fpsc_pkg::ST_MHI: begin
        mul_x = {16'b0, a[47:32]};
        mul_y = {16'b0, tick_frequency};
      end
      fpsc_pkg::ST_PLO: begin
        mul_x = mag[31:0];
        mul_y = tick_period;
      end
      fpsc_pkg::ST_PHI: begin
        mul_x = {16'b0, mag[47:32]};
        mul_y = tick_period;
      end
      fpsc_pkg::ST_DMUL: begin
        mul_x = {16'b0, dyabs};
        mul_y = sx;
      end
      default: begin
        mul_x = 32'b0;
        mul_y = 32'b0;
      end
    endcase
  end

  // Breakpoint segment search: the first breakpoint whose speed lies above s.
  always_comb begin
    idx = IW'(BREAKPOINTS);
    for (int j = BREAKPOINTS - 1; j >= 0; j--) begin
      if (s < bp[j][47:16]) begin
        idx = IW'(j);
      end
    end
    seg_lo = bp[0];
    seg_hi = bp[0];
    for (int j = 1; j < BREAKPOINTS - 1; j++) begin
      if (idx == IW'(j)) begin
        seg_lo = bp[j-1];
        seg_hi = bp[j];
      end
    end
    direct      = 1'b0;
    direct_duty = seg_lo[15:0];
    if (idx == IW'(0)) begin
      direct      = 1'b1;
      direct_duty = bp[0][15:0];
    end else if (idx >= IW'(BREAKPOINTS - 1)) begin
      direct      = 1'b1;
      direct_duty = bp[BREAKPOINTS-1][15:0];
    end else if (seg_hi[47:16] <= seg_lo[47:16]) begin
      direct      = 1'b1;
      direct_duty = seg_lo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fpsc_pkg::ST_IDLE:  if (in_valid) state_next = fpsc_pkg::ST_DIFF;
      fpsc_pkg::ST_DIFF:  state_next = fpsc_pkg::ST_ABS;
      fpsc_pkg::ST_ABS:   state_next = fpsc_pkg::ST_MLO;
      fpsc_pkg::ST_MLO:   state_next = fpsc_pkg::ST_MHI;
      fpsc_pkg::ST_MHI:   state_next = fpsc_pkg::ST_MAG;
      fpsc_pkg::ST_MAG:   state_next = fpsc_pkg::ST_PLO;
      fpsc_pkg::ST_PLO:   state_next = fpsc_pkg::ST_PHI;
      fpsc_pkg::ST_PHI:   state_next = fpsc_pkg::ST_SUM;
      fpsc_pkg::ST_SUM:   state_next = fpsc_pkg::ST_POS;
      fpsc_pkg::ST_POS:   state_next = fpsc_pkg::ST_CNT;
      fpsc_pkg::ST_CNT:   state_next = fpsc_pkg::ST_SEG;
      fpsc_pkg::ST_SEG:   state_next = direct ? fpsc_pkg::ST_DONE : fpsc_pkg::ST_DMUL;
      fpsc_pkg::ST_DMUL:  state_next = fpsc_pkg::ST_DINIT;
      fpsc_pkg::ST_DINIT: state_next = fpsc_pkg::ST_DIV;
      fpsc_pkg::ST_DIV:   if (div_cnt == 4'd0) state_next = fpsc_pkg::ST_DFIN;
      fpsc_pkg::ST_DFIN:  state_next = fpsc_pkg::ST_DONE;
      fpsc_pkg::ST_DONE:  if (!out_valid || out_ready) state_next = fpsc_pkg::ST_IDLE;
      default:            state_next = fpsc_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency <= 16'd1000;
      tick_period    <= 32'd4294967;
      continuous     <= 1'b0;
      for (int j = 0; j < BREAKPOINTS; j++) begin
        bp[j] <= 48'd0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == fpsc_pkg::REG_TICK_FREQUENCY) tick_frequency <= cfg_data[15:0];
      if (cfg_index == fpsc_pkg::REG_TICK_PERIOD)    tick_period    <= cfg_data[31:0];
      if (cfg_index == fpsc_pkg::REG_CONTINUOUS)     continuous     <= cfg_data[0];
      for (int j = 0; j < BREAKPOINTS; j++) begin
        if (cfg_index == fpsc_pkg::REG_BREAKPOINT_0 + fpsc_pkg::CFG_INDEX_W'(j)) begin
          bp[j] <= cfg_data;
        end
      end
    end
  end

  // Tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= 48'd0;
      last_count <= 32'd0;
      step       <= 4'd0;
    end else begin
      if (state == fpsc_pkg::ST_POS) begin
        if (spd_neg) position <= position - msum;
        else         position <= position + msum;
      end
      if (state == fpsc_pkg::ST_CNT) begin
        last_count <= count_now;
        if (count_now != last_count) begin
          if (!spd_neg) step <= (step == fpsc_pkg::LAST_ROW) ? 4'd0 : step + 4'd1;
          else          step <= (step == 4'd0) ? fpsc_pkg::LAST_ROW : step - 4'd1;
          if (continuous) begin
            if (tgt > 32'sd0) position <= position - 48'h10000;
            else              position <= position + 48'h10000;
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      fpsc_pkg::ST_IDLE: begin
        tgt <= target_count;
        lim <= lim_clamped;
      end
      fpsc_pkg::ST_DIFF: diff <= {tgt[31], tgt, 16'b0} - {position[47], position};
      fpsc_pkg::ST_ABS: begin
        a    <= diff[48] ? -diff : diff;
        dneg <= diff[48];
      end
      fpsc_pkg::ST_MLO: prod <= mul_x * mul_y;
      fpsc_pkg::ST_MHI: begin
        acc  <= prod[47:0];
        prod <= mul_x * mul_y;
      end
      fpsc_pkg::ST_MAG: begin
        if (tick_frequency == 16'd0)    mag <= 48'd0;
        else if (a > 49'h0800000000000) mag <= lim_q16;
        else if (full > {16'b0, lim_q16}) mag <= lim_q16;
        else                            mag <= full[47:0];
      end
      fpsc_pkg::ST_PLO: prod <= mul_x * mul_y;
      fpsc_pkg::ST_PHI: begin
        acc  <= {16'b0, prod[63:32]};
        prod <= mul_x * mul_y;
      end
      fpsc_pkg::ST_SUM: msum <= prod[47:0] + acc;
      fpsc_pkg::ST_CNT: begin
        cnt <= count_now;
        spd <= dneg ? -s : s;
      end
      fpsc_pkg::ST_SEG: begin
        y1    <= seg_lo[15:0];
        dyneg <= seg_hi[15:0] < seg_lo[15:0];
        dyabs <= (seg_hi[15:0] < seg_lo[15:0]) ? seg_lo[15:0] - seg_hi[15:0]
                                               : seg_hi[15:0] - seg_lo[15:0];
        sx    <= s - seg_lo[47:16];
        dx    <= seg_hi[47:16] - seg_lo[47:16];
        duty  <= direct_duty;
      end
      fpsc_pkg::ST_DMUL: prod <= mul_x * mul_y;
      fpsc_pkg::ST_DINIT: begin
        // The quotient stays below 2^16, so the upper bits start below the divisor.
        rem     <= prod[47:16];
        nlo     <= prod[15:0];
        quot    <= 16'd0;
        div_cnt <= 4'd15;
      end
      fpsc_pkg::ST_DIV: begin
        if (r2 >= {1'b0, dx}) begin
          rem  <= 32'(r2 - {1'b0, dx});
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem  <= r2[31:0];
          quot <= {quot[14:0], 1'b0};
        end
        nlo     <= {nlo[14:0], 1'b0};
        div_cnt <= div_cnt - 4'd1;
      end
      fpsc_pkg::ST_DFIN: duty <= dyneg ? y1 - quot : y1 + quot;
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fpsc_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fpsc_pkg::ST_DONE && (!out_valid || out_ready)) begin
      high_duty_a   <= fpsc_pkg::high_mask(step)[0] ? duty : 16'd0;
      high_duty_b   <= fpsc_pkg::high_mask(step)[1] ? duty : 16'd0;
      high_duty_c   <= fpsc_pkg::high_mask(step)[2] ? duty : 16'd0;
      high_duty_d   <= fpsc_pkg::high_mask(step)[3] ? duty : 16'd0;
      high_duty_e   <= fpsc_pkg::high_mask(step)[4] ? duty : 16'd0;
      low_side_mask <= fpsc_pkg::low_mask(step);
      phase_index   <= step;
      current_count <= cnt;
      actual_speed  <= spd;
    end
  end

endmodule
